FILE: rtl/iotid_pkg.sv
// ----------------------------------------------------------------------------
// iotid_pkg
// shared types and constants of the i/o timer, interrupt and disk controller
// ----------------------------------------------------------------------------
`default_nettype none

package iotid_pkg;

    localparam int NREGS        = 23;
    localparam int IDX_W        = 5;
    localparam int DATA_W       = 32;
    localparam int PC_W         = 12;
    localparam int CNT_W        = 11;
    localparam int DISK_LATENCY = 1024;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_RETI  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DISK_NONE  = 2'd0,
        DISK_READ  = 2'd1,
        DISK_WRITE = 2'd2
    } disk_cmd_t;

    localparam logic [IDX_W-1:0] R_IRQ0EN  = 5'd0;
    localparam logic [IDX_W-1:0] R_IRQ1EN  = 5'd1;
    localparam logic [IDX_W-1:0] R_IRQ2EN  = 5'd2;
    localparam logic [IDX_W-1:0] R_IRQ0ST  = 5'd3;
    localparam logic [IDX_W-1:0] R_IRQ1ST  = 5'd4;
    localparam logic [IDX_W-1:0] R_HANDLER = 5'd6;
    localparam logic [IDX_W-1:0] R_RETURN  = 5'd7;
    localparam logic [IDX_W-1:0] R_LEDS    = 5'd9;
    localparam logic [IDX_W-1:0] R_DISP    = 5'd10;
    localparam logic [IDX_W-1:0] R_TEN     = 5'd11;
    localparam logic [IDX_W-1:0] R_TCUR    = 5'd12;
    localparam logic [IDX_W-1:0] R_TMAX    = 5'd13;
    localparam logic [IDX_W-1:0] R_DCMD    = 5'd14;
    localparam logic [IDX_W-1:0] R_DSEC    = 5'd15;
    localparam logic [IDX_W-1:0] R_DBUF    = 5'd16;
    localparam logic [IDX_W-1:0] R_DSTAT   = 5'd17;
    localparam logic [IDX_W-1:0] R_MADDR   = 5'd20;
    localparam logic [IDX_W-1:0] R_MDATA   = 5'd21;
    localparam logic [IDX_W-1:0] R_MCMD    = 5'd22;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [PC_W-1:0]   current_pc;
        logic              irq2_line;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_taken;
        logic [PC_W-1:0]   next_pc;
        logic              monitor_write;
        logic [15:0]       monitor_addr;
        logic [7:0]        monitor_data;
        disk_cmd_t         disk_cmd;
        logic [6:0]        disk_sector;
        logic [11:0]       disk_buffer;
        logic              leds_update;
        logic              display_update;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/iotid_core.sv
// ----------------------------------------------------------------------------
// iotid_core
// i/o register bank, timer, interrupt, monitor and disk state; computes the
// result of one item and commits the new state when step is high
// ----------------------------------------------------------------------------
`default_nettype none

module iotid_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire iotid_pkg::item_t   item,
    output iotid_pkg::result_t   res
);

    logic [iotid_pkg::DATA_W-1:0] regs_reg [iotid_pkg::NREGS];
    logic [iotid_pkg::DATA_W-1:0] regs_next [iotid_pkg::NREGS];
    logic [iotid_pkg::PC_W-1:0]   last_pc_reg, last_pc_next;
    logic [iotid_pkg::DATA_W-1:0] leds_shadow_reg, leds_shadow_next;
    logic [iotid_pkg::DATA_W-1:0] disp_shadow_reg, disp_shadow_next;
    logic [iotid_pkg::CNT_W-1:0]  countdown_reg, countdown_next;
    logic                         in_handler_reg, in_handler_next;

    always_comb
    begin
        logic [iotid_pkg::DATA_W-1:0] tcur;
        logic                         irq_pend;
        regs_next        = regs_reg;
        last_pc_next     = last_pc_reg;
        leds_shadow_next = leds_shadow_reg;
        disp_shadow_next = disp_shadow_reg;
        countdown_next   = countdown_reg;
        in_handler_next  = in_handler_reg;
        res              = '0;
        tcur             = '0;
        irq_pend         = 1'b0;
        unique case (item.op)
            iotid_pkg::OP_READ:
            begin
                if (item.reg_index < iotid_pkg::IDX_W'(iotid_pkg::NREGS))
                begin
                    res.read_data = regs_reg[item.reg_index];
                end
            end
            iotid_pkg::OP_WRITE:
            begin
                if (item.reg_index < iotid_pkg::IDX_W'(iotid_pkg::NREGS))
                begin
                    regs_next[item.reg_index] = item.write_data;
                end
            end
            iotid_pkg::OP_RETI:
            begin
                res.irq_taken   = 1'b1;
                res.next_pc     = regs_reg[iotid_pkg::R_RETURN][iotid_pkg::PC_W-1:0];
                in_handler_next = 1'b0;
            end
            default:
            begin
                // timer advances on pc change while the timer is enabled
                if (last_pc_reg != item.current_pc)
                begin
                    last_pc_next = item.current_pc;
                    if (regs_reg[iotid_pkg::R_TEN] == 32'd1)
                    begin
                        tcur = regs_reg[iotid_pkg::R_TCUR] + 32'd1;
                        if (tcur == regs_reg[iotid_pkg::R_TMAX])
                        begin
                            regs_next[iotid_pkg::R_IRQ0ST] = 32'd1;
                            tcur = '0;
                        end
                        regs_next[iotid_pkg::R_TCUR] = tcur;
                    end
                end
                // interrupt entry
                irq_pend =
                    (regs_next[iotid_pkg::R_IRQ0EN] != '0
                        && regs_next[iotid_pkg::R_IRQ0ST] != '0)
                    || (regs_next[iotid_pkg::R_IRQ1EN] != '0
                        && regs_next[iotid_pkg::R_IRQ1ST] != '0)
                    || (regs_next[iotid_pkg::R_IRQ2EN] != '0 && item.irq2_line);
                if (!in_handler_reg && irq_pend)
                begin
                    regs_next[iotid_pkg::R_RETURN] =
                        iotid_pkg::DATA_W'(item.current_pc);
                    in_handler_next = 1'b1;
                    res.irq_taken   = 1'b1;
                    res.next_pc     =
                        regs_next[iotid_pkg::R_HANDLER][iotid_pkg::PC_W-1:0];
                end
                // monitor pixel write
                if (regs_next[iotid_pkg::R_MCMD] == 32'd1)
                begin
                    res.monitor_write = 1'b1;
                    res.monitor_addr  = regs_next[iotid_pkg::R_MADDR][15:0];
                    res.monitor_data  = regs_next[iotid_pkg::R_MDATA][7:0];
                    regs_next[iotid_pkg::R_MCMD] = '0;
                end
                // disk controller
                if (regs_next[iotid_pkg::R_DCMD] != '0 && countdown_reg == '0)
                begin
                    if (regs_next[iotid_pkg::R_DSTAT] == '0)
                    begin
                        countdown_next = iotid_pkg::CNT_W'(iotid_pkg::DISK_LATENCY);
                        regs_next[iotid_pkg::R_DSTAT] = 32'd1;
                        if (regs_next[iotid_pkg::R_DCMD] == 32'd1
                            || regs_next[iotid_pkg::R_DCMD] == 32'd2)
                        begin
                            res.disk_cmd    = iotid_pkg::disk_cmd_t'(
                                regs_next[iotid_pkg::R_DCMD][1:0]);
                            res.disk_sector = regs_next[iotid_pkg::R_DSEC][6:0];
                            res.disk_buffer = regs_next[iotid_pkg::R_DBUF][11:0];
                        end
                    end
                end
                else if (countdown_reg > iotid_pkg::CNT_W'(1))
                begin
                    countdown_next = countdown_reg - iotid_pkg::CNT_W'(1);
                end
                else if (countdown_reg == iotid_pkg::CNT_W'(1))
                begin
                    regs_next[iotid_pkg::R_DCMD]   = '0;
                    regs_next[iotid_pkg::R_DSTAT]  = '0;
                    regs_next[iotid_pkg::R_IRQ1ST] = 32'd1;
                    countdown_next = '0;
                end
                // led and display change flags
                if (regs_next[iotid_pkg::R_LEDS] != leds_shadow_reg)
                begin
                    leds_shadow_next = regs_next[iotid_pkg::R_LEDS];
                    res.leds_update  = 1'b1;
                end
                if (regs_next[iotid_pkg::R_DISP] != disp_shadow_reg)
                begin
                    disp_shadow_next   = regs_next[iotid_pkg::R_DISP];
                    res.display_update = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iotid_pkg::NREGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            last_pc_reg     <= '0;
            leds_shadow_reg <= '0;
            disp_shadow_reg <= '0;
            countdown_reg   <= '0;
            in_handler_reg  <= 1'b0;
        end
        else if (step)
        begin
            regs_reg        <= regs_next;
            last_pc_reg     <= last_pc_next;
            leds_shadow_reg <= leds_shadow_next;
            disp_shadow_reg <= disp_shadow_next;
            countdown_reg   <= countdown_next;
            in_handler_reg  <= in_handler_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/io_timer_irq_disk_controller_unit.sv
// ----------------------------------------------------------------------------
// io_timer_irq_disk_controller_unit
// i/o register block with interval timer, interrupts, monitor port and disk
// dma control
//
//   channel  signals                                   direction
//   req      req_valid/req_ready, op .. irq2_line      in
//   rsp      rsp_valid/rsp_ready, read_data .. display out
//
// one item per cycle sustained while no result stalls; each item is captured
// in the input register and then moves to the result register, which drives
// the result outputs. the state bank is updated when an item moves from the
// input register to the result register. reset clears both valid flags and
// the core state; the input and result data registers are not reset. a
// stalled result holds; the input register keeps accepting while the result
// register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module io_timer_irq_disk_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  reg_index,
    input  wire logic [31:0] write_data,
    input  wire logic [11:0] current_pc,
    input  wire logic        irq2_line,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [31:0]      read_data,
    output logic             irq_taken,
    output logic [11:0]      next_pc,
    output logic             monitor_write,
    output logic [15:0]      monitor_addr,
    output logic [7:0]       monitor_data,
    output logic [1:0]       disk_cmd,
    output logic [6:0]       disk_sector,
    output logic [11:0]      disk_buffer,
    output logic             leds_update,
    output logic             display_update
);

    iotid_pkg::item_t   item_reg;
    logic               item_valid_reg;
    iotid_pkg::result_t res_reg;
    iotid_pkg::result_t res_next;
    logic               res_valid_reg;
    logic               advance;

    assign advance   = item_valid_reg && (!res_valid_reg || rsp_ready);
    assign req_ready = !item_valid_reg || advance;

    iotid_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                item_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.op         <= iotid_pkg::op_t'(op);
            item_reg.reg_index  <= reg_index;
            item_reg.write_data <= write_data;
            item_reg.current_pc <= current_pc;
            item_reg.irq2_line  <= irq2_line;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp_valid      = res_valid_reg;
    assign read_data      = res_reg.read_data;
    assign irq_taken      = res_reg.irq_taken;
    assign next_pc        = res_reg.next_pc;
    assign monitor_write  = res_reg.monitor_write;
    assign monitor_addr   = res_reg.monitor_addr;
    assign monitor_data   = res_reg.monitor_data;
    assign disk_cmd       = res_reg.disk_cmd;
    assign disk_sector    = res_reg.disk_sector;
    assign disk_buffer    = res_reg.disk_buffer;
    assign leds_update    = res_reg.leds_update;
    assign display_update = res_reg.display_update;

endmodule

`default_nettype wire

FILE: rtl/iotid_checker.sv
// ----------------------------------------------------------------------------
// iotid_checker
// port-level checks of the i/o timer, interrupt and disk controller
// ----------------------------------------------------------------------------
`default_nettype none

module iotid_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] read_data,
    input wire logic        irq_taken,
    input wire logic [11:0] next_pc,
    input wire logic        monitor_write,
    input wire logic [15:0] monitor_addr,
    input wire logic [7:0]  monitor_data,
    input wire logic [1:0]  disk_cmd,
    input wire logic [6:0]  disk_sector,
    input wire logic [11:0] disk_buffer
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
            && $stable(next_pc) && $stable(disk_cmd))
        else $error("stalled result changed");

    // no redirect address without a redirect
    a_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !irq_taken |-> next_pc == 12'd0)
        else $error("next_pc set without irq_taken");

    // pixel fields only with a pixel write
    a_mon_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !monitor_write |-> monitor_addr == 16'd0
            && monitor_data == 8'd0)
        else $error("monitor fields set without a write");

    // disk fields only with a started transfer of a known kind
    a_disk: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> disk_cmd == iotid_pkg::DISK_READ
            || disk_cmd == iotid_pkg::DISK_WRITE
            || (disk_cmd == iotid_pkg::DISK_NONE
                && disk_sector == 7'd0 && disk_buffer == 12'd0))
        else $error("bad disk transfer fields");

endmodule

bind io_timer_irq_disk_controller_unit iotid_checker u_iotid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .read_data     (read_data),
    .irq_taken     (irq_taken),
    .next_pc       (next_pc),
    .monitor_write (monitor_write),
    .monitor_addr  (monitor_addr),
    .monitor_data  (monitor_data),
    .disk_cmd      (disk_cmd),
    .disk_sector   (disk_sector),
    .disk_buffer   (disk_buffer)
);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i/o timer, interrupt and disk controller block:
// a directed opening, then tick-heavy random programs (timer wrap, interrupt
// entry and return, monitor writes, disk starts) under four
// handshake pressure settings, each result checked against an item-level model
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  op = 2'd0;
    logic [4:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic [11:0] current_pc = '0;
    logic        irq2_line = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [31:0] read_data;
    logic        irq_taken;
    logic [11:0] next_pc;
    logic        monitor_write;
    logic [15:0] monitor_addr;
    logic [7:0]  monitor_data;
    logic [1:0]  disk_cmd;
    logic [6:0]  disk_sector;
    logic [11:0] disk_buffer;
    logic        leds_update;
    logic        display_update;

    // model of the register bank and controller state
    logic [iotid_pkg::DATA_W-1:0] io_bank [iotid_pkg::NREGS] = '{default: '0};
    logic [iotid_pkg::PC_W-1:0]   last_pc = '0;
    logic [iotid_pkg::DATA_W-1:0] leds_seen = '0;
    logic [iotid_pkg::DATA_W-1:0] disp_seen = '0;
    logic [iotid_pkg::CNT_W-1:0]  dma_count = '0;
    logic                         in_handler = 1'b0;

    iotid_pkg::item_t   pending_items[$];
    iotid_pkg::result_t expected_results[$];
    iotid_pkg::item_t   held_item;
    iotid_pkg::result_t want;
    logic [11:0]        gen_pc = 12'd1;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        error_count = 0;

    io_timer_irq_disk_controller_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .op             (op),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .current_pc     (current_pc),
        .irq2_line      (irq2_line),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_data      (read_data),
        .irq_taken      (irq_taken),
        .next_pc        (next_pc),
        .monitor_write  (monitor_write),
        .monitor_addr   (monitor_addr),
        .monitor_data   (monitor_data),
        .disk_cmd       (disk_cmd),
        .disk_sector    (disk_sector),
        .disk_buffer    (disk_buffer),
        .leds_update    (leds_update),
        .display_update (display_update)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic iotid_pkg::result_t step_io_block(input iotid_pkg::item_t it);
        iotid_pkg::result_t res;
        res = '0;
        case (it.op)
            iotid_pkg::OP_READ:
            begin
                if (it.reg_index < iotid_pkg::IDX_W'(iotid_pkg::NREGS))
                    res.read_data = io_bank[it.reg_index];
            end
            iotid_pkg::OP_WRITE:
            begin
                if (it.reg_index < iotid_pkg::IDX_W'(iotid_pkg::NREGS))
                    io_bank[it.reg_index] = it.write_data;
            end
            iotid_pkg::OP_RETI:
            begin
                res.irq_taken = 1'b1;
                res.next_pc = io_bank[iotid_pkg::R_RETURN][iotid_pkg::PC_W-1:0];
                in_handler = 1'b0;
            end
            default:
            begin
                if (it.current_pc != last_pc)
                begin
                    last_pc = it.current_pc;
                    if (io_bank[iotid_pkg::R_TEN] == 32'd1)
                    begin
                        io_bank[iotid_pkg::R_TCUR] = io_bank[iotid_pkg::R_TCUR] + 32'd1;
                        if (io_bank[iotid_pkg::R_TCUR] == io_bank[iotid_pkg::R_TMAX])
                        begin
                            io_bank[iotid_pkg::R_IRQ0ST] = 32'd1;
                            io_bank[iotid_pkg::R_TCUR] = '0;
                        end
                    end
                end
                if (!in_handler &&
                    ((io_bank[iotid_pkg::R_IRQ0EN] != 0 && io_bank[iotid_pkg::R_IRQ0ST] != 0) ||
                     (io_bank[iotid_pkg::R_IRQ1EN] != 0 && io_bank[iotid_pkg::R_IRQ1ST] != 0) ||
                     (io_bank[iotid_pkg::R_IRQ2EN] != 0 && it.irq2_line)))
                begin
                    io_bank[iotid_pkg::R_RETURN] = 32'(it.current_pc);
                    in_handler = 1'b1;
                    res.irq_taken = 1'b1;
                    res.next_pc = io_bank[iotid_pkg::R_HANDLER][iotid_pkg::PC_W-1:0];
                end
                if (io_bank[iotid_pkg::R_MCMD] == 32'd1)
                begin
                    res.monitor_write = 1'b1;
                    res.monitor_addr = io_bank[iotid_pkg::R_MADDR][15:0];
                    res.monitor_data = io_bank[iotid_pkg::R_MDATA][7:0];
                    io_bank[iotid_pkg::R_MCMD] = '0;
                end
                if (io_bank[iotid_pkg::R_DCMD] != 0 && dma_count == '0)
                begin
                    if (io_bank[iotid_pkg::R_DSTAT] == 0)
                    begin
                        dma_count = iotid_pkg::CNT_W'(iotid_pkg::DISK_LATENCY);
                        io_bank[iotid_pkg::R_DSTAT] = 32'd1;
                        if (io_bank[iotid_pkg::R_DCMD] == 32'(iotid_pkg::DISK_READ) ||
                            io_bank[iotid_pkg::R_DCMD] == 32'(iotid_pkg::DISK_WRITE))
                        begin
                            res.disk_cmd =
                                iotid_pkg::disk_cmd_t'(io_bank[iotid_pkg::R_DCMD][1:0]);
                            res.disk_sector = io_bank[iotid_pkg::R_DSEC][6:0];
                            res.disk_buffer = io_bank[iotid_pkg::R_DBUF][11:0];
                        end
                    end
                end
                else if (dma_count > iotid_pkg::CNT_W'(1))
                    dma_count = dma_count - iotid_pkg::CNT_W'(1);
                else if (dma_count == iotid_pkg::CNT_W'(1))
                begin
                    io_bank[iotid_pkg::R_DCMD] = '0;
                    io_bank[iotid_pkg::R_DSTAT] = '0;
                    io_bank[iotid_pkg::R_IRQ1ST] = 32'd1;
                    dma_count = '0;
                end
                if (io_bank[iotid_pkg::R_LEDS] != leds_seen)
                begin
                    leds_seen = io_bank[iotid_pkg::R_LEDS];
                    res.leds_update = 1'b1;
                end
                if (io_bank[iotid_pkg::R_DISP] != disp_seen)
                begin
                    disp_seen = io_bank[iotid_pkg::R_DISP];
                    res.display_update = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    task automatic add_item(input iotid_pkg::op_t o, input logic [4:0] idx,
                            input logic [31:0] d, input logic [11:0] pc,
                            input logic irq);
        iotid_pkg::item_t it;
        it.op = o;
        it.reg_index = idx;
        it.write_data = d;
        it.current_pc = pc;
        it.irq2_line = irq;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_write_value(input logic [4:0] idx);
        if ($urandom_range(7) == 0)
            return $urandom();
        case (idx)
            iotid_pkg::R_TMAX:
                return $urandom_range(12, 2);
            iotid_pkg::R_TCUR, iotid_pkg::R_DCMD:
                return $urandom_range(3);
            iotid_pkg::R_TEN, iotid_pkg::R_MCMD:
                return 32'($urandom_range(3) != 0);
            iotid_pkg::R_IRQ0EN, iotid_pkg::R_IRQ1EN, iotid_pkg::R_IRQ2EN:
                return 32'($urandom_range(3) != 0);
            iotid_pkg::R_IRQ0ST, iotid_pkg::R_IRQ1ST, iotid_pkg::R_DSTAT:
                return 32'($urandom_range(3) == 0);
            default:
                return $urandom();
        endcase
    endfunction

    task automatic queue_random_op();
        iotid_pkg::item_t it;
        int unsigned      roll;
        int unsigned      pc_roll;
        it.op = iotid_pkg::OP_READ;
        it.write_data = $urandom();
        it.reg_index = 5'($urandom_range(31));
        it.current_pc = 12'($urandom_range(4095));
        it.irq2_line = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            pc_roll = $urandom_range(9);
            if (pc_roll == 1)
                gen_pc = 12'($urandom_range(4095));
            else if (pc_roll != 0)
                gen_pc = gen_pc + 12'd1;
            it.op = iotid_pkg::OP_TICK;
            it.current_pc = gen_pc;
            it.irq2_line = ($urandom_range(7) == 0);
        end
        else if (roll < 89)
        begin
            it.op = iotid_pkg::OP_WRITE;
            it.reg_index = ($urandom_range(7) == 0) ? 5'($urandom_range(31, 23))
                                                    : 5'($urandom_range(22));
            it.write_data = pick_write_value(it.reg_index);
        end
        else if (roll >= 95)
        begin
            // handler epilogue: usually clear irq0st, irq1st or unused register 5, then return
            if ($urandom_range(3) != 0)
                add_item(iotid_pkg::OP_WRITE, 5'($urandom_range(5, 3)), '0, gen_pc, 1'b0);
            it.op = iotid_pkg::OP_RETI;
        end
        pending_items.push_back(it);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            op         <= iotid_pkg::OP_TICK;
            reg_index  <= '0;
            write_data <= '0;
            current_pc <= '0;
            irq2_line  <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_results.push_back(step_io_block(held_item));
            if (!req_valid || req_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_item = pending_items.pop_front();
                    req_valid  <= 1'b1;
                    op         <= held_item.op;
                    reg_index  <= held_item.reg_index;
                    write_data <= held_item.write_data;
                    current_pc <= held_item.current_pc;
                    irq2_line  <= held_item.irq2_line;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    report_error("result transfer with no prediction pending");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", read_data, want.read_data);
                    check_field("irq_taken", 32'(irq_taken), 32'(want.irq_taken));
                    check_field("next_pc", 32'(next_pc), 32'(want.next_pc));
                    check_field("monitor_write", 32'(monitor_write),
                                32'(want.monitor_write));
                    check_field("monitor_addr", 32'(monitor_addr),
                                32'(want.monitor_addr));
                    check_field("monitor_data", 32'(monitor_data),
                                32'(want.monitor_data));
                    check_field("disk_cmd", 32'(disk_cmd), 32'(want.disk_cmd));
                    check_field("disk_sector", 32'(disk_sector), 32'(want.disk_sector));
                    check_field("disk_buffer", 32'(disk_buffer), 32'(want.disk_buffer));
                    check_field("leds_update", 32'(leds_update), 32'(want.leds_update));
                    check_field("display_update", 32'(display_update),
                                32'(want.display_update));
                end
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int unsigned idle_by_phase [5];
        int unsigned stall_by_phase [5];
        idle_by_phase = '{0, 60, 0, 23, 0};
        stall_by_phase = '{0, 0, 60, 23, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_item(iotid_pkg::OP_READ, iotid_pkg::R_IRQ0EN, '0, '0, 1'b0);
        add_item(iotid_pkg::OP_READ, 5'd31, '1, '1, 1'b1);
        add_item(iotid_pkg::OP_WRITE, 5'd31, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_LEDS, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DISP, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_HANDLER, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_IRQ2EN, 32'd1, '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b1);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'hfff, 1'b1);
        add_item(iotid_pkg::OP_RETI, '1, '1, 12'hfff, 1'b1);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_TMAX, 32'd2, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_TEN, 32'd1, '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_MADDR, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_MDATA, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_MCMD, 32'd1, '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DSTAT, 32'd1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DCMD, 32'(iotid_pkg::DISK_WRITE),
                 '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DSEC, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DBUF, '1, '0, 1'b0);
        add_item(iotid_pkg::OP_WRITE, iotid_pkg::R_DSTAT, '0, '0, 1'b0);
        add_item(iotid_pkg::OP_TICK, '0, '0, 12'd1, 1'b0);
        wait_drain();

        // tick-heavy random programs, one batch per handshake pressure phase
        for (int ph = 0; ph < 5; ph++)
        begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            repeat (180) queue_random_op();
            wait_drain();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("[io_timer_irq_disk_controller_unit] OK");
        else
            $display("[io_timer_irq_disk_controller_unit] ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("[io_timer_irq_disk_controller_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
